[design/tlv_chk_pkg.sv]
// shared types and constants for the tlv frame checksum checker
`timescale 1ns / 1ps
package tlv_chk_pkg;

  localparam int unsigned CountW      = 17;
  localparam int unsigned TotalW      = CountW + 1;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam int unsigned OverheadBytes = 6;  // header four plus footer two

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SHORT     = 2'd1,
    STATUS_LEN_ERR   = 2'd2,
    STATUS_CSUM_ERR  = 2'd3
  } frame_status_t;

  // one byte word as it moves from the input register to the checker core
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } byte_word_t;

endpackage

[design/tlv_chk_if.sv]
// stream interfaces for byte words and frame results
`timescale 1ns / 1ps
interface tlv_chk_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface tlv_chk_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_tag;
  logic [15:0] payload_length;
  logic [1:0]  frame_status;

  modport source (output valid, output frame_tag, output payload_length,
                  output frame_status, input ready);
  modport sink (input valid, input frame_tag, input payload_length,
                input frame_status, output ready);
endinterface

[design/tlv_frame_checksum_checker.sv]
// top level of the tlv frame checker with 16-bit additive checksum
//
//   port        dir   word contents
//   in_bus      sink  frame_byte[7:0], frame_end
//   out_bus     src   frame_tag[15:0], payload_length[15:0], frame_status[1:0]
//
// one byte word per cycle sustained while the result register is not stalled;
// a result leaves through the result register after its closing byte passes the input register
// rst_n is synchronous and clears all frame state and both valid flags
// a stalled result register holds only a closing byte back; other bytes keep
// flowing into the frame state
`timescale 1ns / 1ps
module tlv_frame_checksum_checker
  import tlv_chk_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  tlv_chk_byte_if.sink     in_bus,
  tlv_chk_result_if.source out_bus
);

  logic       word_valid;
  logic       word_ready;
  byte_word_t word;

  // input register
  tlv_chk_ingress u_ingress (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .word_valid (word_valid),
    .word       (word),
    .word_ready (word_ready)
  );

  // checker core with result register
  tlv_chk_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_valid (word_valid),
    .word       (word),
    .word_ready (word_ready),
    .out_bus    (out_bus)
  );

endmodule

[design/tlv_chk_ingress.sv]
// input register stage for incoming byte words
`timescale 1ns / 1ps
module tlv_chk_ingress
  import tlv_chk_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  tlv_chk_byte_if.sink  in_bus,
  output logic          word_valid,
  output byte_word_t    word,
  input  logic          word_ready
);

  logic       valid_r;
  byte_word_t word_r;
  logic       load;

  // take a new word when the register is empty or drains this cycle
  assign in_bus.ready = !valid_r || word_ready;
  assign load         = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      valid_r <= in_bus.valid;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (load) begin
      word_r.frame_byte <= in_bus.frame_byte;
      word_r.frame_end  <= in_bus.frame_end;
    end
  end

  assign word_valid = valid_r;
  assign word       = word_r;

endmodule

[design/tlv_chk_core.sv]
// frame state, checksum accumulation and result register
`timescale 1ns / 1ps
module tlv_chk_core
  import tlv_chk_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            word_valid,
  input  byte_word_t      word,
  output logic            word_ready,
  tlv_chk_result_if.source out_bus
);

  logic [CountW-1:0] count_r, count_nxt;
  logic [15:0]       sum_r, sum_nxt;
  logic [15:0]       tag_r, tag_nxt;
  logic [15:0]       len_r, len_nxt;
  logic [15:0]       trail_r, trail_nxt;

  logic              out_valid_r;
  logic [15:0]       out_tag_r, out_tag_nxt;
  logic [15:0]       out_len_r, out_len_nxt;
  frame_status_t     out_status_r, out_status_nxt;

  logic              room;
  logic              take;
  logic [TotalW-1:0] total;
  logic [15:0]       footer;

  // a closing word needs room in the result register, other words do not
  assign room       = !out_valid_r || out_bus.ready;
  assign word_ready = !word.frame_end || room;
  assign take       = word_valid && word_ready;

  // next frame state and result for the word at hand
  always_comb begin
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    case (count_r)
      CountW'(0): tag_nxt = {tag_r[15:8], word.frame_byte};
      CountW'(1): tag_nxt = {word.frame_byte, tag_r[7:0]};
      CountW'(2): len_nxt = {len_r[15:8], word.frame_byte};
      CountW'(3): len_nxt = {word.frame_byte, len_r[7:0]};
      default: ;
    endcase

    // byte two places back leaves the window and joins the sum
    sum_nxt   = (count_r >= CountW'(2)) ? sum_r + {8'd0, trail_r[15:8]} : sum_r;
    trail_nxt = {trail_r[7:0], word.frame_byte};
    count_nxt = (count_r == CountMax) ? count_r : count_r + CountW'(1);

    total  = {1'b0, count_r} + TotalW'(1);
    footer = {word.frame_byte, trail_r[7:0]};

    out_tag_nxt = tag_nxt;
    out_len_nxt = len_nxt;
    if (total < TotalW'(OverheadBytes)) begin
      out_tag_nxt    = 16'd0;
      out_len_nxt    = 16'd0;
      out_status_nxt = STATUS_SHORT;
    end else if ({{(TotalW-16){1'b0}}, len_nxt} != total - TotalW'(OverheadBytes)) begin
      out_status_nxt = STATUS_LEN_ERR;
    end else if (footer != sum_nxt) begin
      out_status_nxt = STATUS_CSUM_ERR;
    end else begin
      out_status_nxt = STATUS_OK;
    end

    // frame end clears the count, sum and byte window of the frame
    if (word.frame_end) begin
      count_nxt = '0;
      sum_nxt   = '0;
      trail_nxt = '0;
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      tag_r   <= '0;
      len_r   <= '0;
      trail_r <= '0;
    end else if (take) begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      trail_r <= trail_nxt;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && word.frame_end) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take && word.frame_end) begin
      out_tag_r    <= out_tag_nxt;
      out_len_r    <= out_len_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.frame_tag      = out_tag_r;
  assign out_bus.payload_length = out_len_r;
  assign out_bus.frame_status   = out_status_r;

endmodule
